FILE: design/lkv_pkg.sv
// Shared constants and codes for the LRU key/value cache.
// No dependencies; lkv_if, the top level and lkv_engine use this package.
package lkv_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 1;
  localparam int STATUS_W  = 3;
  localparam int CAP_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [FUNC_W-1:0] FN_GET = 1'b0;
  localparam logic [FUNC_W-1:0] FN_PUT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_INS     = 3'd2,
    ST_EVICT   = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  localparam logic [DATA_W-1:0] MINUS_ONE = '1;

endpackage

FILE: design/lkv_if.sv
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on lkv_pkg for field widths.
interface lkv_req_if;
  logic                                valid;
  logic                                ready;
  logic        [lkv_pkg::FUNC_W-1:0]   func;
  logic signed [lkv_pkg::DATA_W-1:0]   key;
  logic signed [lkv_pkg::DATA_W-1:0]   value;
  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [lkv_pkg::STATUS_W-1:0] status;
  logic signed [lkv_pkg::DATA_W-1:0]   read_value;
  logic signed [lkv_pkg::DATA_W-1:0]   evicted_key;
  modport source (output valid, status, read_value, evicted_key, input ready);
  modport sink   (input valid, status, read_value, evicted_key, output ready);
endinterface

interface lkv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lkv_pkg::CAP_W-1:0]        data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/lru_key_value_cache_top.sv
// LRU key/value cache: top level with the capacity register.
// Depends on lkv_pkg, lkv_if, lkv_engine and lkv_mem.
//
// Usage:
//   in_ch  : request channel (func get/put, key, value), valid/ready.
//   out_ch : response channel (status, read_value, evicted_key), one
//            response per request, held until taken.
//   cfg_ch : capacity write; always ready, takes effect on the next
//            request. Write it only while no request is in flight.
// Timing: a request walks all DEPTH entries of the entry memory once to
//   find a hit, the LRU victim and a free slot, and if the store changes
//   it walks them again to rewrite ages and the entry. A get hit or a put
//   that writes an entry takes both passes; a miss, a put of a present key,
//   or a put into an empty store at capacity zero (evicted at once) takes
//   the first pass only. No new request is accepted until the last one has
//   been handed to the output register. The single read port of the entry
//   memory is why each pass reads the entries one at a time.
// Stall: one finished response waits in the output register while the
//   next request is accepted and worked on; that request then holds in its
//   last step until the output register is free.
// Reset: rst_n low clears all valid bits, the occupancy and capacity=16.
module lru_key_value_cache_top #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lkv_req_if.sink   in_ch,
  lkv_rsp_if.source out_ch,
  lkv_cfg_if.sink   cfg_ch
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;

  // capacity register; saturation to DEPTH happens in the engine
  assign cfg_ch.ready = 1'b1;
  assign cap_nxt      = cfg_ch.valid ? cfg_ch.data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lkv_engine #(.DEPTH(DEPTH)) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cap_i  (cap_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

FILE: design/lkv_mem.sv
// Simple dual-port entry memory, one write and one registered read port.
// No package dependency.
module lkv_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 68
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lkv_engine.sv
// Lookup/update sequencer: scans the entry memory, then, if the store changes, rewrites ages and the entry.
// Depends on lkv_pkg, lkv_if and lkv_mem.
module lkv_engine #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lkv_pkg::CAP_W-1:0] cap_i,
  lkv_req_if.sink                   in_ch,
  lkv_rsp_if.source                 out_ch
);
  import lkv_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 2 * DATA_W + AW;   // {key, value, age}
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDT, S_DONE} state_t;
  typedef enum logic [1:0] {U_HIT, U_EVICT, U_INS} upd_t;

  state_t              state_r, state_nxt;
  upd_t                mode_r, mode_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [DATA_W-1:0]   key_r, key_nxt, val_r, val_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, occ_r, occ_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_age_r, hit_age_nxt;
  logic [DATA_W-1:0]   hit_val_r, hit_val_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic                vic_r, vic_nxt;
  logic [AW-1:0]       vic_idx_r, vic_idx_nxt, vic_age_r, vic_age_nxt;
  logic [DATA_W-1:0]   vic_key_r, vic_key_nxt;
  logic                free_r, free_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic [AW-1:0]       tgt_r, tgt_nxt;
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  status_t             res_st_r, res_st_nxt;
  logic [DATA_W-1:0]   res_rv_r, res_rv_nxt, res_ek_r, res_ek_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [DATA_W-1:0]   out_rv_r, out_rv_nxt, out_ek_r, out_ek_nxt;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [EW-1:0]       wr_data, rd_data;
  logic [DATA_W-1:0]   rd_key, rd_val;
  logic [AW-1:0]       rd_age;
  logic                rd_vld;
  logic [CW-1:0]       cap_eff;

  lkv_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key = rd_data[EW-1 -: DATA_W];
  assign rd_val = rd_data[AW +: DATA_W];
  assign rd_age = rd_data[AW-1:0];
  assign rd_vld = valid_r[pidx_r];
  assign cap_eff = (int'(cap_i) > DEPTH) ? DEPTH_C : CW'(cap_i);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.evicted_key = out_ek_r;

  always_comb begin
    state_nxt = state_r;     mode_nxt = mode_r;       func_nxt = func_r;
    key_nxt = key_r;         val_nxt = val_r;         cnt_nxt = cnt_r;
    occ_nxt = occ_r;         pend_nxt = 1'b0;         pidx_nxt = pidx_r;
    hit_nxt = hit_r;         hit_age_nxt = hit_age_r; hit_val_nxt = hit_val_r;
    hit_idx_nxt = hit_idx_r; vic_nxt = vic_r;         vic_idx_nxt = vic_idx_r;
    vic_age_nxt = vic_age_r; vic_key_nxt = vic_key_r; free_nxt = free_r;
    free_idx_nxt = free_idx_r; tgt_nxt = tgt_r;       valid_nxt = valid_r;
    res_st_nxt = res_st_r;   res_rv_nxt = res_rv_r;   res_ek_nxt = res_ek_r;
    out_st_nxt = out_st_r;   out_rv_nxt = out_rv_r;   out_ek_nxt = out_ek_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pidx_r;
    wr_data = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          key_nxt   = in_ch.key;
          val_nxt   = in_ch.value;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          vic_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (cnt_r != DEPTH_C) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end
        if (pend_r) begin
          if (rd_vld && rd_key == key_r && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
            hit_age_nxt = rd_age;
            hit_val_nxt = rd_val;
          end
          if (rd_vld && (!vic_r || rd_age > vic_age_r)) begin
            vic_nxt     = 1'b1;
            vic_idx_nxt = pidx_r;
            vic_age_nxt = rd_age;
            vic_key_nxt = rd_key;
          end
          if (!rd_vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
        end else if (cnt_r == DEPTH_C) begin
          // scan complete: classify the request
          cnt_nxt    = '0;
          res_rv_nxt = MINUS_ONE;
          res_ek_nxt = '0;
          state_nxt  = S_DONE;
          case (func_r)
            FN_GET: begin
              if (hit_r) begin
                res_st_nxt = ST_HIT;
                res_rv_nxt = hit_val_r;
                mode_nxt   = U_HIT;
                tgt_nxt    = hit_idx_r;
                state_nxt  = S_UPDT;
              end else begin
                res_st_nxt = ST_MISS;
              end
            end
            default: begin
              if (hit_r) begin
                res_st_nxt = ST_PRESENT;
              end else if (occ_r >= cap_eff) begin
                res_st_nxt = ST_EVICT;
                if (occ_r == '0) begin
                  res_ek_nxt = key_r;   // empty store, capacity zero
                end else begin
                  res_ek_nxt = vic_key_r;
                  mode_nxt   = U_EVICT;
                  tgt_nxt    = vic_idx_r;
                  state_nxt  = S_UPDT;
                end
              end else begin
                res_st_nxt = ST_INS;
                mode_nxt   = U_INS;
                tgt_nxt    = free_idx_r;
                state_nxt  = S_UPDT;
              end
            end
          endcase
        end
      end

      S_UPDT: begin
        if (cnt_r != DEPTH_C) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end
        if (pend_r) begin
          if (pidx_r == tgt_r) begin
            wr_en = 1'b1;
            if (mode_r == U_HIT) begin
              wr_data = {rd_key, rd_val, AW'(0)};
            end else begin
              wr_data = {key_r, val_r, AW'(0)};
            end
          end else if (rd_vld) begin
            wr_en = 1'b1;
            if (mode_r == U_HIT && rd_age >= hit_age_r) begin
              wr_data = rd_data;
            end else begin
              wr_data = {rd_key, rd_val, rd_age + AW'(1)};
            end
          end
        end else if (cnt_r == DEPTH_C) begin
          if (mode_r == U_INS) begin
            valid_nxt[tgt_r] = 1'b1;
            occ_nxt          = occ_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_rv_nxt    = res_rv_r;
          out_ek_nxt    = res_ek_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      occ_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      occ_r       <= occ_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    mode_r     <= mode_nxt;     func_r     <= func_nxt;    key_r      <= key_nxt;
    val_r      <= val_nxt;      pidx_r     <= pidx_nxt;    hit_r      <= hit_nxt;
    hit_age_r  <= hit_age_nxt;  hit_val_r  <= hit_val_nxt; hit_idx_r  <= hit_idx_nxt;
    vic_r      <= vic_nxt;      vic_idx_r  <= vic_idx_nxt; vic_age_r  <= vic_age_nxt;
    vic_key_r  <= vic_key_nxt;  free_r     <= free_nxt;    free_idx_r <= free_idx_nxt;
    tgt_r      <= tgt_nxt;      res_st_r   <= res_st_nxt;  res_rv_r   <= res_rv_nxt;
    res_ek_r   <= res_ek_nxt;   out_st_r   <= out_st_nxt;  out_rv_r   <= out_rv_nxt;
    out_ek_r   <= out_ek_nxt;
  end

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy out of step with valid bits");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_mem_idle_outside_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> (!wr_en && !rd_en))
    else $error("memory access outside a scan or update pass");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised without a finished request");
`endif

endmodule
